FILE: hdl/sparse_row_matrix_store_unit_macros.svh
// Assertion macros for the sparse row matrix store.
// Used by the port checker; no other dependencies.
`ifndef SPARSE_ROW_MATRIX_STORE_UNIT_MACROS_SVH
`define SPARSE_ROW_MATRIX_STORE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SRMS_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication
`define SRMS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

FILE: hdl/srms_pkg.sv
// Shared types, codes and helpers for the sparse row matrix store.
// No dependencies.
`default_nettype none

package srms_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 6;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_SET    = 3'd1,
		OP_ADD    = 3'd2,
		OP_GET    = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic [ST_W-1:0]   status;
	} res_t;

	// signed Q16.16 add, clamped to the 32-bit range
	function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
		input logic [DATA_W-1:0] b);
		logic [DATA_W:0]   s;
		logic [DATA_W-1:0] r;
		s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		if (s[DATA_W] != s[DATA_W-1]) begin
			r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r = s[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/srms_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module srms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/srms_seq.sv
// Command sequencer: pointer lookup, append, row scan with read-modify-write,
// and the clearing sweep. Drives the row pointer and entry RAMs; uses srms_pkg.
`default_nettype none

module srms_seq #(
	parameter int MATRIX_SIZE = 64,
	parameter int NZ_MAX = 256,
	localparam int RS_DEPTH = MATRIX_SIZE + 1,
	localparam int RW = $clog2(RS_DEPTH),
	localparam int AW = $clog2(NZ_MAX),
	localparam int PW = $clog2(NZ_MAX + 1),
	localparam int EW = srms_pkg::IDX_W + srms_pkg::DATA_W
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire logic [srms_pkg::OP_W-1:0]    op,
	input  wire logic [srms_pkg::IDX_W-1:0]   row,
	input  wire logic [srms_pkg::IDX_W-1:0]   column,
	input  wire logic [srms_pkg::DATA_W-1:0]  value,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output srms_pkg::res_t                    res,
	output logic                              rs_we,
	output logic [RW-1:0]                     rs_waddr,
	output logic [PW-1:0]                     rs_wdata,
	output logic [RW-1:0]                     rs_raddr,
	input  wire logic [PW-1:0]                rs_rdata,
	output logic                              en_we,
	output logic [AW-1:0]                     en_waddr,
	output logic [EW-1:0]                     en_wdata,
	output logic [AW-1:0]                     en_raddr,
	input  wire logic [EW-1:0]                en_rdata
);

	import srms_pkg::*;

	localparam int CLR_LEN = (RS_DEPTH > NZ_MAX) ? RS_DEPTH : NZ_MAX;
	localparam int CW = $clog2(CLR_LEN);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_LO,
		S_HI,
		S_PTR,
		S_SCAN,
		S_RES
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic              clr_op_q;
	logic [OP_W-1:0]   op_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [DATA_W-1:0] val_q;
	logic [PW-1:0]     lo_q;
	logic [PW-1:0]     hi_q;
	logic [PW-1:0]     idx_q;
	logic              hit_q;
	logic              v_s1;
	logic [AW-1:0]     addr_s1;
	res_t              res_q;

	logic              row_bad;
	logic [RW-1:0]     row_lo_addr;
	logic [RW-1:0]     row_hi_addr;
	logic [PW-1:0]     pos;
	logic              full;
	logic [PW-1:0]     hi_clamp;
	logic              issue;
	logic              scan_hit;
	logic [DATA_W-1:0] ent_val;
	logic [DATA_W-1:0] new_val;
	logic              is_write_op;

	assign row_bad     = (32'(row) >= MATRIX_SIZE);
	assign row_lo_addr = RW'(row_q);
	assign row_hi_addr = RW'(row_q) + RW'(1);

	// empty next-row pointer: seed from this row's start
	assign pos      = (rs_rdata != '0) ? rs_rdata : lo_q;
	assign full     = (32'(pos) >= NZ_MAX);
	assign hi_clamp = (32'(rs_rdata) > NZ_MAX) ? PW'(NZ_MAX) : rs_rdata;

	assign issue       = (idx_q < hi_q);
	assign ent_val     = en_rdata[DATA_W-1:0];
	assign scan_hit    = v_s1 && (en_rdata[EW-1 -: IDX_W] == col_q);
	assign is_write_op = (op_q == OP_SET) || (op_q == OP_ADD);
	assign new_val     = (op_q == OP_SET) ? val_q : sat_add(ent_val, val_q);

	assign item_ready = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_RES);
	assign res        = res_q;

	always_comb begin
		rs_we    = 1'b0;
		rs_waddr = row_hi_addr;
		rs_wdata = pos + PW'(1);
		rs_raddr = (state_q == S_LO) ? row_lo_addr : row_hi_addr;
		en_we    = 1'b0;
		en_waddr = addr_s1;
		en_wdata = {col_q, new_val};
		en_raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_CLR: begin
				rs_we    = (32'(cnt_q) < RS_DEPTH);
				rs_waddr = cnt_q[RW-1:0];
				rs_wdata = '0;
				en_we    = (32'(cnt_q) < NZ_MAX);
				en_waddr = cnt_q[AW-1:0];
				en_wdata = '0;
			end
			S_PTR: begin
				rs_we    = (op_q == OP_APPEND) && !full;
				en_we    = (op_q == OP_APPEND) && !full;
				en_waddr = pos[AW-1:0];
				en_wdata = {col_q, val_q};
			end
			S_SCAN: begin
				// write-back goes to the previous index, never the one being read
				en_we = scan_hit && is_write_op;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			cnt_q    <= '0;
			clr_op_q <= 1'b0;
			v_s1     <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(CLR_LEN - 1)) begin
						if (clr_op_q) begin
							res_q   <= '{read_value: '0, status: ST_DONE};
							state_q <= S_RES;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						op_q     <= op;
						row_q    <= row;
						col_q    <= column;
						val_q    <= value;
						hit_q    <= 1'b0;
						clr_op_q <= (op == OP_CLEAR);
						unique case (op)
							OP_APPEND, OP_SET, OP_ADD, OP_GET: begin
								if (row_bad) begin
									res_q   <= '{read_value: '0, status: ST_NOT_FOUND};
									state_q <= S_RES;
								end else begin
									state_q <= S_LO;
								end
							end
							OP_CLEAR: begin
								cnt_q    <= '0;
								state_q  <= S_CLR;
							end
							default: begin
								res_q   <= '{read_value: '0, status: ST_DONE};
								state_q <= S_RES;
							end
						endcase
					end
				end
				S_LO: begin
					state_q <= S_HI;
				end
				S_HI: begin
					lo_q    <= rs_rdata;
					state_q <= S_PTR;
				end
				S_PTR: begin
					if (op_q == OP_APPEND) begin
						res_q   <= '{read_value: '0, status: full ? ST_FULL : ST_DONE};
						state_q <= S_RES;
					end else begin
						idx_q   <= lo_q;
						hi_q    <= hi_clamp;
						v_s1    <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// a stale v_s1 left by a get is cleared again before the next scan
					v_s1    <= issue;
					addr_s1 <= idx_q[AW-1:0];
					if (issue) begin
						idx_q <= idx_q + PW'(1);
					end
					if (scan_hit) begin
						hit_q <= 1'b1;
					end
					if (scan_hit && (op_q == OP_GET)) begin
						res_q   <= '{read_value: ent_val, status: ST_DONE};
						state_q <= S_RES;
					end else if (!issue) begin
						res_q   <= '{read_value: '0,
							status: (hit_q || scan_hit) ? ST_DONE : ST_NOT_FOUND};
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sparse_row_matrix_store_unit.sv
// Sparse matrix store in compressed row form, Q16.16 values. One command per
// beat: append, set, add (saturating), get, clear. After reset, and for each
// clear, a sweep over max(MATRIX_SIZE+1, NZ_MAX) addresses zeroes both RAMs while
// no beat is taken. Each command first reads the row's two pointers; append then
// writes its entry, while set, add and get scan the row's entries, one entry RAM
// read per cycle (get stops at the first match). Rows out of range and unused op
// codes go straight to the result. The result sits in an output register, so
// the next beat is taken while it waits.
// Uses srms_pkg, srms_seq and srms_ram.
`default_nettype none

module sparse_row_matrix_store_unit #(
	parameter int MATRIX_SIZE = 64,
	parameter int NZ_MAX = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output logic                                    item_ready,
	input  wire logic        [srms_pkg::OP_W-1:0]   op,
	input  wire logic        [srms_pkg::IDX_W-1:0]  row,
	input  wire logic        [srms_pkg::IDX_W-1:0]  column,
	input  wire logic signed [srms_pkg::DATA_W-1:0] value,
	output logic                                    result_valid,
	input  wire logic                               result_ready,
	output logic signed      [srms_pkg::DATA_W-1:0] read_value,
	output logic             [srms_pkg::ST_W-1:0]   status
);

	import srms_pkg::*;

	localparam int RS_DEPTH = MATRIX_SIZE + 1;
	localparam int RW = $clog2(RS_DEPTH);
	localparam int AW = $clog2(NZ_MAX);
	localparam int PW = $clog2(NZ_MAX + 1);
	localparam int EW = IDX_W + DATA_W;

	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          rs_we;
	logic [RW-1:0] rs_waddr;
	logic [PW-1:0] rs_wdata;
	logic [RW-1:0] rs_raddr;
	logic [PW-1:0] rs_rdata;
	logic          en_we;
	logic [AW-1:0] en_waddr;
	logic [EW-1:0] en_wdata;
	logic [AW-1:0] en_raddr;
	logic [EW-1:0] en_rdata;

	logic out_valid_q;
	res_t out_q;

	srms_seq #(
		.MATRIX_SIZE(MATRIX_SIZE),
		.NZ_MAX(NZ_MAX)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.op        (op),
		.row       (row),
		.column    (column),
		.value     (value),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rs_we     (rs_we),
		.rs_waddr  (rs_waddr),
		.rs_wdata  (rs_wdata),
		.rs_raddr  (rs_raddr),
		.rs_rdata  (rs_rdata),
		.en_we     (en_we),
		.en_waddr  (en_waddr),
		.en_wdata  (en_wdata),
		.en_raddr  (en_raddr),
		.en_rdata  (en_rdata)
	);

	// row pointer table
	srms_ram #(
		.WIDTH(PW),
		.DEPTH(RS_DEPTH)
	) u_row_start (
		.clk  (clk),
		.we   (rs_we),
		.waddr(rs_waddr),
		.wdata(rs_wdata),
		.raddr(rs_raddr),
		.rdata(rs_rdata)
	);

	// column and value of each stored entry, packed per word
	srms_ram #(
		.WIDTH(EW),
		.DEPTH(NZ_MAX)
	) u_entry (
		.clk  (clk),
		.we   (en_we),
		.waddr(en_waddr),
		.wdata(en_wdata),
		.raddr(en_raddr),
		.rdata(en_rdata)
	);

	assign res_ready = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign read_value   = out_q.read_value;
	assign status       = out_q.status;

endmodule

`default_nettype wire

FILE: hdl/srms_checker.sv
// Port-level checks for the sparse row matrix store, bound to the top level.
// Uses srms_pkg and sparse_row_matrix_store_unit_macros.svh.
`default_nettype none

`include "sparse_row_matrix_store_unit_macros.svh"

module srms_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               item_valid,
	input wire logic                               item_ready,
	input wire logic                               result_valid,
	input wire logic                               result_ready,
	input wire logic signed [srms_pkg::DATA_W-1:0] read_value,
	input wire logic        [srms_pkg::ST_W-1:0]   status
);

	import srms_pkg::*;

	// a stalled result beat holds
	`SRMS_ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(read_value) && $stable(status), "result beat changed while stalled")

	// one command in flight: taking a beat closes the input side
	`SRMS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, item_valid && item_ready, !item_ready, "input taken again right after a beat")

	// only a successful command carries a value
	`SRMS_ASSERT_IMPLY(a_value_zero, clk, arst_n, result_valid && (status != ST_DONE), read_value == '0, "nonzero value with a failed status")

endmodule

bind sparse_row_matrix_store_unit srms_checker u_srms_checker (.*);

`default_nettype wire

FILE: dv/sparse_row_matrix_store_unit_test.sv
// Testbench for sparse_row_matrix_store_unit: directed table then random build/query episodes,
// every result beat checked against an in-bench compressed row store model or a fixed result.
// Depends on srms_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module sparse_row_matrix_store_unit_test;
	import srms_pkg::*;

	localparam int ROWS        = 64;
	localparam int NZ_CAP      = 256;
	localparam int ITEM_TARGET = 1550;
	localparam int TAIL_CYCLES = 300;  // covers a clear sweep or a full-row scan

	localparam logic [OP_W-1:0]   OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0]   OP_SPARE_HI = 3'd7;
	localparam logic [DATA_W-1:0] Q_MAX       = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] Q_MIN       = 32'h8000_0000;
	localparam logic [DATA_W-1:0] Q_NEG_ONE   = 32'hFFFF_FFFF;
	localparam longint SUM_HI = 64'sd2147483647;
	localparam longint SUM_LO = -64'sd2147483648;

	typedef struct {
		logic [OP_W-1:0]   cmd;
		logic [IDX_W-1:0]  r;
		logic [IDX_W-1:0]  c;
		logic [DATA_W-1:0] v;
		bit                typed;
		res_t              want;
	} vector_t;

	typedef struct packed {
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
	} entry_key_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     item_valid = 1'b0;
	logic                     item_ready;
	logic [OP_W-1:0]          op = '0;
	logic [IDX_W-1:0]         row = '0;
	logic [IDX_W-1:0]         column = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     result_valid;
	logic                     result_ready = 1'b0;
	logic signed [DATA_W-1:0] read_value;
	logic [ST_W-1:0]          status;

	// model copy of the store
	logic [8:0]        row_ptr [0:ROWS] = '{default: '0};
	logic [IDX_W-1:0]  col_of [0:NZ_CAP-1] = '{default: '0};
	logic [DATA_W-1:0] val_of [0:NZ_CAP-1] = '{default: '0};

	res_t       pending_results [$];
	entry_key_t stored_keys [$];
	res_t       want;
	int         send_idle_pct = 37;
	int         recv_idle_pct = 74;
	int         items_sent = 0;
	int         results_checked = 0;
	int         refused_count = 0;
	int         mismatch_count = 0;
	int         episodes = 0;
	int         fill_episodes = 0;

	localparam int N_DIRECTED = 25;
	vector_t directed [N_DIRECTED] = '{
		'{OP_GET,      6'd0,  6'd0,  32'd0,        1'b1, '{32'd0, ST_NOT_FOUND}},
		'{OP_SET,      6'd63, 6'd63, Q_MAX,        1'b1, '{32'd0, ST_NOT_FOUND}},
		'{OP_ADD,      6'd0,  6'd5,  Q_NEG_ONE,    1'b1, '{32'd0, ST_NOT_FOUND}},
		'{OP_APPEND,   6'd0,  6'd0,  Q_MAX,        1'b1, '{32'd0, ST_DONE}},
		'{OP_APPEND,   6'd0,  6'd63, Q_MIN,        1'b1, '{32'd0, ST_DONE}},
		'{OP_GET,      6'd0,  6'd0,  32'd0,        1'b1, '{Q_MAX, ST_DONE}},
		// saturate high, then low
		'{OP_ADD,      6'd0,  6'd0,  32'd1,        1'b1, '{32'd0, ST_DONE}},
		'{OP_GET,      6'd0,  6'd0,  32'd0,        1'b1, '{Q_MAX, ST_DONE}},
		'{OP_ADD,      6'd0,  6'd63, Q_MIN,        1'b1, '{32'd0, ST_DONE}},
		'{OP_GET,      6'd0,  6'd63, 32'd0,        1'b1, '{Q_MIN, ST_DONE}},
		// duplicate column, set hits both copies
		'{OP_APPEND,   6'd0,  6'd0,  32'h0001_8000, 1'b0, '{32'd0, ST_DONE}},
		'{OP_SET,      6'd0,  6'd0,  32'h1234_5678, 1'b0, '{32'd0, ST_DONE}},
		'{OP_GET,      6'd0,  6'd0,  32'd0,        1'b0, '{32'd0, ST_DONE}},
		// row 1 skipped: row 2 seeds from a zero pointer and overwrites entry 0
		'{OP_APPEND,   6'd2,  6'd7,  32'hFFFF_0000, 1'b0, '{32'd0, ST_DONE}},
		'{OP_GET,      6'd1,  6'd0,  32'd0,        1'b0, '{32'd0, ST_DONE}},
		'{OP_GET,      6'd0,  6'd0,  32'd0,        1'b0, '{32'd0, ST_DONE}},
		'{OP_GET,      6'd2,  6'd7,  32'd0,        1'b0, '{32'd0, ST_DONE}},
		'{OP_APPEND,   6'd63, 6'd63, 32'hA5A5_5A5A, 1'b0, '{32'd0, ST_DONE}},
		'{OP_GET,      6'd63, 6'd63, 32'd0,        1'b0, '{32'd0, ST_DONE}},
		'{OP_SPARE_LO, 6'd42, 6'd21, Q_MAX,        1'b1, '{32'd0, ST_DONE}},
		'{OP_SPARE_HI, 6'd21, 6'd42, Q_MIN,        1'b1, '{32'd0, ST_DONE}},
		'{OP_CLEAR,    6'd63, 6'd63, Q_NEG_ONE,    1'b1, '{32'd0, ST_DONE}},
		'{OP_GET,      6'd0,  6'd0,  32'd0,        1'b1, '{32'd0, ST_NOT_FOUND}},
		'{OP_APPEND,   6'd63, 6'd0,  Q_NEG_ONE,    1'b0, '{32'd0, ST_DONE}},
		'{OP_ADD,      6'd63, 6'd0,  Q_MIN,        1'b0, '{32'd0, ST_DONE}}
	};

	sparse_row_matrix_store_unit #(
		.MATRIX_SIZE(ROWS),
		.NZ_MAX(NZ_CAP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.op(op),
		.row(row),
		.column(column),
		.value(value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.read_value(read_value),
		.status(status)
	);

	always #1 clk = ~clk;

	// runs one command on the model store and returns the result it gives
	function automatic res_t apply_command(input logic [OP_W-1:0] cmd, input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
		res_t        res;
		int unsigned ri;
		int unsigned pos;
		int unsigned lo;
		int unsigned hi;
		longint      sum;
		bit          hit;
		res.read_value = '0;
		res.status = ST_DONE;
		ri = r;
		hit = 1'b0;
		case (cmd)
			OP_CLEAR: begin
				for (int i = 0; i <= ROWS; i++) row_ptr[i] = '0;
				for (int i = 0; i < NZ_CAP; i++) begin
					col_of[i] = '0;
					val_of[i] = '0;
				end
			end
			OP_APPEND: begin
				pos = row_ptr[ri + 1];
				if (pos == 0) pos = row_ptr[ri];
				if (pos >= NZ_CAP) begin
					res.status = ST_FULL;
				end else begin
					row_ptr[ri + 1] = 9'(pos + 1);
					col_of[pos] = c;
					val_of[pos] = v;
				end
			end
			OP_SET, OP_ADD, OP_GET: begin
				lo = row_ptr[ri];
				hi = row_ptr[ri + 1];
				if (hi > NZ_CAP) hi = NZ_CAP;
				for (int unsigned i = lo; i < hi; i++) begin
					if (col_of[i] == c) begin
						hit = 1'b1;
						if (cmd == OP_SET) begin
							val_of[i] = v;
						end else if (cmd == OP_ADD) begin
							sum = longint'($signed(val_of[i])) + longint'($signed(v));
							if (sum > SUM_HI) sum = SUM_HI;
							if (sum < SUM_LO) sum = SUM_LO;
							val_of[i] = sum[DATA_W-1:0];
						end else begin
							res.read_value = val_of[i];
							break;
						end
					end
				end
				if (!hit) res.status = ST_NOT_FOUND;
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return DATA_W'($urandom_range(0, 32'h3FFFF)) - 32'h2_0000;
			default: return $urandom();
		endcase
	endfunction

	// drives one beat; waits for acceptance, then records the expected result
	task automatic send_beat(input logic [OP_W-1:0] cmd, input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v,
		input bit typed = 1'b0, input res_t fixed = '0);
		res_t predicted;
		case (items_sent * 3 / ITEM_TARGET)
			0: begin
				send_idle_pct = 37;
				recv_idle_pct = 74;
			end
			1: begin
				send_idle_pct = 74;
				recv_idle_pct = 37;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		op <= cmd;
		row <= r;
		column <= c;
		value <= v;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		predicted = apply_command(cmd, r, c, v);
		pending_results.push_back(typed ? fixed : predicted);
		if (cmd <= OP_CLEAR) items_sent++;
		if (cmd == OP_APPEND && predicted.status == ST_FULL) refused_count++;
		@(negedge clk);
	endtask

	task automatic send_noise();
		send_beat(OP_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, ROWS - 1)),
			IDX_W'($urandom_range(0, 63)), pick_value());
	endtask

	// clear, build rows in ascending order, then query mostly what was built
	task automatic run_episode(input bit fill);
		int               r;
		int               n;
		int               total;
		int               target;
		int               queries;
		logic [IDX_W-1:0] c;
		entry_key_t       k;
		logic [OP_W-1:0]  q_op;
		send_beat(OP_CLEAR, IDX_W'($urandom()), IDX_W'($urandom()), $urandom());
		stored_keys.delete();
		r = $urandom_range(0, 3);
		total = 0;
		target = fill ? 270 : $urandom_range(3, 24);
		while (total < target && r < ROWS) begin
			n = fill ? $urandom_range(1, 40) : $urandom_range(1, 4);
			c = IDX_W'($urandom_range(0, 7));
			repeat (n) begin
				send_beat(OP_APPEND, IDX_W'(r), c, pick_value());
				stored_keys.push_back('{IDX_W'(r), c});
				total++;
				c = c + IDX_W'($urandom_range(0, 6));  // zero step gives a duplicate
				if ($urandom_range(0, 11) == 0) send_noise();
			end
			r += ($urandom_range(0, 9) == 0) ? 2 : 1;
		end
		queries = fill ? 60 : $urandom_range(8, 30);
		repeat (queries) begin
			if (stored_keys.size() > 0 && $urandom_range(0, 99) < 85) begin
				k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
			end else begin
				k = '{IDX_W'($urandom_range(0, ROWS - 1)), IDX_W'($urandom_range(0, 63))};
			end
			case ($urandom_range(0, 3))
				0: q_op = OP_SET;
				1: q_op = OP_ADD;
				default: q_op = OP_GET;
			endcase
			send_beat(q_op, k.r, k.c, pick_value());
			if ($urandom_range(0, 19) == 0) send_noise();
		end
		episodes++;
		if (fill) fill_episodes++;
	endtask

	always @(negedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result beat: read_value %h status %0d",
					$time, read_value, status);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (read_value !== want.read_value) begin
					mismatch_count++;
					$display("%0t: read_value expected %h actual %h",
						$time, want.read_value, read_value);
				end
				if (status !== want.status) begin
					mismatch_count++;
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_beat(directed[i].cmd, directed[i].r, directed[i].c, directed[i].v,
				directed[i].typed, directed[i].want);
		end
		while (items_sent < ITEM_TARGET) run_episode(episodes % 5 == 4);
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d commands: %0d directed, %0d build/query episodes (%0d filled to capacity)",
			items_sent, N_DIRECTED, episodes, fill_episodes);
		$display("%0d result beats checked, %0d appends refused on a full table",
			results_checked, refused_count);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timed out with %0d results outstanding", pending_results.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
